// ===== hdl/i2c_register_master_macros.svh =====
// assertion macros used by the i2c register master engine
`ifndef I2C_REGISTER_MASTER_MACROS_SVH
`define I2C_REGISTER_MASTER_MACROS_SVH

// concurrent check on clk, off while in reset
`define I2CRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication check on clk
`define I2CRM_ASSERT_IMP(lbl, pre, post, msg) \
	`I2CRM_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// ===== hdl/i2crm_pkg.sv =====
// types, constants and the transaction scripts of the i2c register master
package i2crm_pkg;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_HIGH, PH_ST_SETUP, PH_TX_HOLD, PH_TX_LOW, PH_TX_HIGH,
		PH_TX_ALOW, PH_TX_ASET, PH_TX_AHIGH, PH_TX_ATAIL, PH_RX_HIGH, PH_RX_LOW,
		PH_RX_ASET, PH_RX_AHIGH, PH_RX_AHOLD, PH_RX_TAIL, PH_SP_SETUP, PH_SP_HIGH,
		PH_SP_HOLD
	} phase_t;

	typedef enum logic [2:0] {
		OP_END, OP_START, OP_TXA, OP_TXR, OP_TXRD, OP_TXV, OP_RX, OP_STOP
	} op_t;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_READ_REG = 3'd1;
	localparam logic [2:0] KIND_READ_BUF = 3'd2;
	localparam logic [2:0] KIND_WRITE_REG = 3'd3;
	localparam logic [2:0] KIND_READ_BYTE = 3'd4;
	localparam logic [2:0] KIND_WRITE_BYTE = 3'd5;

	localparam logic [1:0] REG_SETUP = 2'd0;
	localparam logic [1:0] REG_HOLD = 2'd1;
	localparam logic [1:0] REG_LOW = 2'd2;
	localparam logic [1:0] REG_HIGH = 2'd3;

	localparam logic [7:0] SETUP_RESET = 8'd1;
	localparam logic [7:0] HOLD_RESET = 8'd1;
	localparam logic [7:0] LOW_RESET = 8'd2;
	localparam logic [7:0] HIGH_RESET = 8'd7;

	typedef struct packed {
		logic [7:0] setup_ticks;
		logic [7:0] hold_ticks;
		logic [7:0] low_ticks;
		logic [7:0] high_ticks;
	} cfg_t;

	typedef struct packed {
		logic        is_cmd;
		logic [2:0]  kind;
		logic [7:0]  device_address;
		logic [7:0]  register_index;
		logic [7:0]  write_value;
		logic [15:0] byte_count;
		logic        sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] received_byte;
		logic       last_byte;
		logic       done_res;
		logic       ack_ok;
	} res_t;

	function automatic op_t script_op(input logic [2:0] kind, input logic [2:0] stage);
		op_t op;
		op = OP_END;
		case (kind)
			KIND_READ_REG, KIND_READ_BUF: begin
				case (stage)
					3'd0: op = OP_START;
					3'd1: op = OP_TXA;
					3'd2: op = OP_TXR;
					3'd3: op = OP_START;
					3'd4: op = OP_TXRD;
					3'd5: op = OP_RX;
					3'd6: op = OP_STOP;
					default: op = OP_END;
				endcase
			end
			KIND_WRITE_REG: begin
				case (stage)
					3'd0: op = OP_START;
					3'd1: op = OP_TXA;
					3'd2: op = OP_TXR;
					3'd3: op = OP_TXV;
					3'd4: op = OP_STOP;
					default: op = OP_END;
				endcase
			end
			KIND_READ_BYTE: begin
				case (stage)
					3'd0: op = OP_START;
					3'd1: op = OP_TXRD;
					3'd2: op = OP_RX;
					3'd3: op = OP_STOP;
					default: op = OP_END;
				endcase
			end
			KIND_WRITE_BYTE: begin
				case (stage)
					3'd0: op = OP_START;
					3'd1: op = OP_TXA;
					3'd2: op = OP_TXV;
					3'd3: op = OP_STOP;
					default: op = OP_END;
				endcase
			end
			default: op = OP_END;
		endcase
		return op;
	endfunction

	// a tick count of zero acts as one
	function automatic logic [7:0] ticks_of(input logic [7:0] t);
		return (t == 8'd0) ? 8'd1 : t;
	endfunction

endpackage

// ===== hdl/i2crm_fifo.sv =====
// small register queue between the front, the engine and the result side
module i2crm_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push_ok, pop_ok;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ===== hdl/i2crm_front.sv =====
// front: classifies each incoming item as command or tick and queues it
module i2crm_front #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [2:0]           func,
	input  logic [7:0]           device_address,
	input  logic [7:0]           register_index,
	input  logic [7:0]           write_value,
	input  logic [15:0]          byte_count,
	input  logic                 sda_sample,
	input  logic                 item_pop,
	output i2crm_pkg::item_t     item,
	output logic                 item_empty
);
	import i2crm_pkg::*;

	item_t cls;
	logic [$bits(item_t)-1:0] q_rdata;

	always_comb begin
		cls.is_cmd = func inside {[KIND_READ_REG:KIND_WRITE_BYTE]};
		cls.kind = cls.is_cmd ? func : KIND_NONE;
		cls.device_address = device_address;
		cls.register_index = register_index;
		cls.write_value = write_value;
		// only buffer reads take the count; single reads move one byte
		if (func == KIND_READ_BUF) begin
			cls.byte_count = byte_count;
		end else if (func == KIND_READ_REG || func == KIND_READ_BYTE) begin
			cls.byte_count = 16'd1;
		end else begin
			cls.byte_count = 16'd0;
		end
		cls.sda_sample = sda_sample;
	end

	i2crm_fifo #(.W($bits(item_t)), .DEPTH(DEPTH)) u_q (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wdata(cls), .full(full),
		.pop(item_pop), .rdata(q_rdata), .empty(item_empty)
	);

	assign item = item_t'(q_rdata);
endmodule

// ===== hdl/i2crm_engine.sv =====
// back end: bit sequencer that runs the transaction scripts one tick per item
`include "i2c_register_master_macros.svh"
module i2crm_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  i2crm_pkg::cfg_t  cfg,
	input  i2crm_pkg::item_t item,
	input  logic             item_valid,
	output logic             item_pop,
	input  logic             res_full,
	output logic             res_push,
	output i2crm_pkg::res_t  res
);
	import i2crm_pkg::*;

	phase_t      phase_q, n_phase;
	logic [7:0]  delay_q, n_delay;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [15:0] bytes_q, n_bytes;
	logic [2:0]  kind_q, n_kind;
	logic [7:0]  addr_q, n_addr;
	logic [7:0]  reg_q, n_reg;
	logic [7:0]  data_q, n_data;
	logic        acked_q, n_acked;
	logic [2:0]  stage_q, n_stage;
	logic        scl_q, n_scl, sda_q, n_sda;

	logic        fire;
	logic        do_begin;
	logic [2:0]  begin_stage;
	logic [7:0]  dec;
	op_t         sel_op;
	logic [2:0]  sel_stage;
	logic        found;
	op_t         cand;
	logic [3:0]  idx;

	assign fire = item_valid && !res_full;
	assign item_pop = fire;
	assign res_push = fire;

	// next op of the script at or after begin_stage, skipping guarded ops
	always_comb begin
		sel_op = OP_END;
		sel_stage = begin_stage;
		found = 1'b0;
		for (int i = 0; i < 8; i++) begin
			idx = {1'b0, begin_stage} + 4'(i);
			cand = script_op(n_kind, idx[2:0]);
			if (!found && !idx[3]) begin
				if (!(((cand == OP_TXR || cand == OP_TXV) && !n_acked)
						|| (cand == OP_RX && !(n_acked && n_bytes != 16'd0)))) begin
					found = 1'b1;
					sel_op = cand;
					sel_stage = idx[2:0];
				end
			end
		end
	end

	always_comb begin
		n_phase = phase_q; n_delay = delay_q; n_bit = bit_q; n_shift = shift_q;
		n_bytes = bytes_q; n_kind = kind_q; n_addr = addr_q; n_reg = reg_q;
		n_data = data_q; n_acked = acked_q; n_stage = stage_q;
		n_scl = scl_q; n_sda = sda_q;
		do_begin = 1'b0;
		begin_stage = stage_q + 3'd1;
		res = '0;
		res.scl_drive_low = scl_q;
		res.sda_drive_low = sda_q;
		dec = (delay_q != 8'd0) ? delay_q - 8'd1 : 8'd0;
		if (phase_q == PH_IDLE) begin
			if (item.is_cmd) begin
				n_kind = item.kind;
				n_addr = item.device_address;
				n_reg = item.register_index;
				n_data = item.write_value;
				n_bytes = item.byte_count;
				n_acked = 1'b0;
				do_begin = 1'b1;
				begin_stage = 3'd0;
			end
		end else begin
			n_delay = dec;
			if (dec == 8'd0) begin
				case (phase_q)
					PH_ST_HIGH: begin
						n_phase = PH_ST_SETUP; n_scl = 1'b0; n_sda = 1'b1;
						n_delay = ticks_of(cfg.setup_ticks);
					end
					PH_ST_SETUP: do_begin = 1'b1;
					PH_TX_HOLD: begin
						n_phase = PH_TX_LOW; n_scl = 1'b1; n_sda = !shift_q[7];
						n_delay = ticks_of(cfg.low_ticks);
					end
					PH_TX_LOW: begin
						n_phase = PH_TX_HIGH; n_scl = 1'b0;
						n_delay = ticks_of(cfg.high_ticks);
					end
					PH_TX_HIGH: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit = (bit_q != 4'd0) ? bit_q - 4'd1 : 4'd0;
						n_scl = 1'b1;
						if (n_bit != 4'd0) begin
							n_phase = PH_TX_HOLD; n_delay = ticks_of(cfg.hold_ticks);
						end else begin
							n_phase = PH_TX_ALOW; n_delay = ticks_of(cfg.low_ticks);
						end
					end
					PH_TX_ALOW: begin
						n_phase = PH_TX_ASET; n_scl = 1'b1; n_sda = 1'b0;
						n_delay = ticks_of(cfg.setup_ticks);
					end
					PH_TX_ASET: begin
						n_phase = PH_TX_AHIGH; n_scl = 1'b0; n_sda = 1'b0;
						n_delay = ticks_of(cfg.high_ticks);
					end
					PH_TX_AHIGH: begin
						n_acked = !item.sda_sample;
						n_phase = PH_TX_ATAIL; n_scl = 1'b1; n_sda = 1'b0;
						n_delay = ticks_of(cfg.low_ticks);
					end
					PH_TX_ATAIL: do_begin = 1'b1;
					PH_RX_HIGH: begin
						n_shift = {shift_q[6:0], item.sda_sample};
						n_bit = (bit_q != 4'd0) ? bit_q - 4'd1 : 4'd0;
						if (n_bit == 4'd0) begin
							res.byte_valid = 1'b1;
							res.received_byte = n_shift;
							res.last_byte = (bytes_q == 16'd1);
						end
						n_phase = PH_RX_LOW; n_scl = 1'b1;
						n_delay = ticks_of(cfg.low_ticks);
					end
					PH_RX_LOW: begin
						if (bit_q != 4'd0) begin
							n_phase = PH_RX_HIGH; n_scl = 1'b0;
							n_delay = ticks_of(cfg.high_ticks);
						end else begin
							// ack every byte but the last
							n_phase = PH_RX_ASET; n_scl = 1'b1;
							n_sda = (bytes_q != 16'd1);
							n_delay = ticks_of(cfg.setup_ticks);
						end
					end
					PH_RX_ASET: begin
						n_phase = PH_RX_AHIGH; n_scl = 1'b0;
						n_delay = ticks_of(cfg.high_ticks);
					end
					PH_RX_AHIGH: begin
						n_phase = PH_RX_AHOLD; n_scl = 1'b1;
						n_delay = ticks_of(cfg.setup_ticks);
					end
					PH_RX_AHOLD: begin
						n_phase = PH_RX_TAIL; n_scl = 1'b1; n_sda = 1'b0;
						n_delay = ticks_of(cfg.low_ticks);
					end
					PH_RX_TAIL: begin
						n_bytes = (bytes_q != 16'd0) ? bytes_q - 16'd1 : 16'd0;
						if (n_bytes != 16'd0) begin
							n_shift = 8'd0; n_bit = 4'd8;
							n_phase = PH_RX_HIGH; n_scl = 1'b0;
							n_delay = ticks_of(cfg.high_ticks);
						end else begin
							do_begin = 1'b1;
						end
					end
					PH_SP_SETUP: begin
						n_phase = PH_SP_HIGH; n_scl = 1'b0; n_sda = 1'b1;
						n_delay = ticks_of(cfg.high_ticks);
					end
					PH_SP_HIGH: begin
						n_phase = PH_SP_HOLD; n_scl = 1'b0; n_sda = 1'b0;
						n_delay = ticks_of(cfg.hold_ticks);
					end
					PH_SP_HOLD: begin
						res.done_res = 1'b1;
						res.ack_ok = acked_q;
						n_phase = PH_IDLE; n_scl = 1'b0; n_sda = 1'b0; n_delay = 8'd0;
					end
					default: begin
						n_phase = PH_IDLE; n_scl = 1'b0; n_sda = 1'b0; n_delay = 8'd0;
					end
				endcase
			end
		end
		if (do_begin) begin
			n_stage = sel_stage;
			case (sel_op)
				OP_START: begin
					n_phase = PH_ST_HIGH; n_scl = 1'b0; n_sda = 1'b0;
					n_delay = ticks_of(cfg.high_ticks);
				end
				OP_TXA, OP_TXRD, OP_TXR, OP_TXV: begin
					case (sel_op)
						OP_TXA: n_shift = n_addr;
						OP_TXRD: n_shift = n_addr | 8'h01;
						OP_TXR: n_shift = n_reg;
						default: n_shift = n_data;
					endcase
					n_bit = 4'd8;
					n_phase = PH_TX_HOLD; n_scl = 1'b1;
					n_delay = ticks_of(cfg.hold_ticks);
				end
				OP_RX: begin
					n_shift = 8'd0; n_bit = 4'd8;
					n_phase = PH_RX_HIGH; n_scl = 1'b0;
					n_delay = ticks_of(cfg.high_ticks);
				end
				OP_STOP: begin
					n_phase = PH_SP_SETUP; n_scl = 1'b1; n_sda = 1'b1;
					n_delay = ticks_of(cfg.setup_ticks);
				end
				default: begin
					n_phase = PH_IDLE; n_scl = 1'b0; n_sda = 1'b0; n_delay = 8'd0;
				end
			endcase
		end
		res.busy_res = (n_phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; delay_q <= '0; bit_q <= '0; shift_q <= '0;
			bytes_q <= '0; kind_q <= '0; addr_q <= '0; reg_q <= '0; data_q <= '0;
			acked_q <= 1'b0; stage_q <= '0; scl_q <= 1'b0; sda_q <= 1'b0;
		end else if (fire) begin
			phase_q <= n_phase; delay_q <= n_delay; bit_q <= n_bit; shift_q <= n_shift;
			bytes_q <= n_bytes; kind_q <= n_kind; addr_q <= n_addr; reg_q <= n_reg;
			data_q <= n_data; acked_q <= n_acked; stage_q <= n_stage;
			scl_q <= n_scl; sda_q <= n_sda;
		end
	end

	`I2CRM_ASSERT_IMP(a_done_not_busy, fire && res.done_res, !res.busy_res, "done while busy")
	`I2CRM_ASSERT_IMP(a_idle_released, phase_q == PH_IDLE, !scl_q && !sda_q, "drive in idle")
	`I2CRM_ASSERT(a_bit_range, bit_q <= 4'd8, "bit counter out of range")
	`I2CRM_ASSERT_IMP(a_byte_in_rx, fire && res.byte_valid, phase_q == PH_RX_HIGH,
		"byte outside receive")
endmodule

// ===== hdl/i2c_register_master.sv =====
// top level of the i2c register master: config port, front, engine, result queue
//  channel  | handshake         | payload
//  config   | psel/penable/pwr  | paddr, pwdata, prdata
//  items    | push / full       | func .. sda_sample
//  results  | pop / empty       | scl_drive_low .. ack_ok
// one item per clock unless a queue stalls; each item is one sequencer tick
// an accepted item is queued, then stepped; its result is queued for the ports
// either side may stall alone; the queues of QUEUE_DEPTH items absorb it
// reset clears queues, engine state and the tick registers to their defaults
module i2c_register_master #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  func,
	input  logic [7:0]  device_address,
	input  logic [7:0]  register_index,
	input  logic [7:0]  write_value,
	input  logic [15:0] byte_count,
	input  logic        sda_sample,
	output logic        empty,
	input  logic        pop,
	output logic        scl_drive_low,
	output logic        sda_drive_low,
	output logic        busy_res,
	output logic        byte_valid,
	output logic [7:0]  received_byte,
	output logic        last_byte,
	output logic        done_res,
	output logic        ack_ok
);
	import i2crm_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	logic  item_empty, item_pop;
	logic  res_full, res_push;
	res_t  res, res_out;
	logic [$bits(res_t)-1:0] res_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_ticks <= SETUP_RESET;
			cfg_q.hold_ticks <= HOLD_RESET;
			cfg_q.low_ticks <= LOW_RESET;
			cfg_q.high_ticks <= HIGH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SETUP: cfg_q.setup_ticks <= pwdata[7:0];
				REG_HOLD: cfg_q.hold_ticks <= pwdata[7:0];
				REG_LOW: cfg_q.low_ticks <= pwdata[7:0];
				REG_HIGH: cfg_q.high_ticks <= pwdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SETUP: prdata = {24'd0, cfg_q.setup_ticks};
			REG_HOLD: prdata = {24'd0, cfg_q.hold_ticks};
			REG_LOW: prdata = {24'd0, cfg_q.low_ticks};
			REG_HIGH: prdata = {24'd0, cfg_q.high_ticks};
			default: prdata = '0;
		endcase
	end

	i2crm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.func(func), .device_address(device_address), .register_index(register_index),
		.write_value(write_value), .byte_count(byte_count), .sda_sample(sda_sample),
		.item_pop(item_pop), .item(item), .item_empty(item_empty)
	);

	i2crm_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item(item), .item_valid(!item_empty), .item_pop(item_pop),
		.res_full(res_full), .res_push(res_push), .res(res)
	);

	i2crm_fifo #(.W($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk(clk), .arst_n(arst_n),
		.push(res_push), .wdata(res), .full(res_full),
		.pop(pop), .rdata(res_rdata), .empty(empty)
	);

	assign res_out = res_t'(res_rdata);
	assign scl_drive_low = res_out.scl_drive_low;
	assign sda_drive_low = res_out.sda_drive_low;
	assign busy_res = res_out.busy_res;
	assign byte_valid = res_out.byte_valid;
	assign received_byte = res_out.received_byte;
	assign last_byte = res_out.last_byte;
	assign done_res = res_out.done_res;
	assign ack_ok = res_out.ack_ok;
endmodule
